// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file gtr_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GTR_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define GTR_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/gtr_pkg.sv =====
`default_nettype none

package gtr_pkg;

    // Fixed formats of the block.
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_OUT     = 16;
    localparam int CNT_W       = $clog2(MAX_OUT);
    localparam int STEP_W      = 5;
    localparam int POS_W       = 32;
    localparam int TAKEN_W     = 16;
    localparam int INC_W       = 21;
    localparam int GAIN_W      = 17;
    localparam int CFG_DATA_W  = 21;
    localparam int T_W         = 20;
    localparam int EF_W        = 24;
    localparam int U_W         = 23;
    localparam int W_W         = 22;
    localparam int ACC_W       = 48;
    localparam int V_W         = 32;
    localparam int OP_W        = 32;
    localparam int P_W         = 64;

    localparam int ONE_Q       = 1 << FRAC_BITS;
    localparam int UNITY_INC   = 65536;
    // Exact floor division by three for operands below 2**22.
    localparam int RECIP3      = 5592406;
    localparam int RECIP3_SH   = 24;
    // Bias that keeps the divide-by-three operand non-negative.
    localparam int DIV_OFS     = 3 * (1 << 20);
    localparam int DIV_K       = 1 << 20;
    // Half of the 6.0 divisor, in Q units.
    localparam int RD_BIAS     = 3 * ONE_Q;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first_of_grain;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_sample;
        logic                          last_of_run;
        logic                          grain_done;
    } out_item_t;

    typedef enum logic [1:0] {
        REG_INCREMENT    = 2'd0,
        REG_USE_CUBIC    = 2'd1,
        REG_GRAIN_FRAMES = 2'd2,
        REG_GAIN         = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_CALC,
        S_ADV,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_QUAD,
        MODE_CUBIC,
        MODE_COPY
    } mode_t;

    // Multiplier operand pairs.
    typedef enum logic [3:0] {
        MUL_NONE, MUL_AT, MUL_CD, MUL_ED, MUL_TF, MUL_EC, MUL_UR, MUL_AF,
        MUL_TD, MUL_TC, MUL_H0, MUL_H1, MUL_H2, MUL_H3, MUL_VG
    } mul_sel_t;

    // Destinations of the registered product.
    typedef enum logic [4:0] {
        WB_NONE, WB_TLD, WB_E, WB_F, WB_U, WB_W0Z, WB_W0N, WB_W1R17,
        WB_W2N16, WB_W2N17, WB_W3R17, WB_W3P, WB_ACCLD, WB_ACCADD,
        WB_VLD, WB_VXLD, WB_OUT
    } wb_sel_t;

    typedef struct packed {
        mul_sel_t mul;
        wb_sel_t  wb;
        logic     fin;
    } micro_t;

    typedef struct packed {
        logic     accept;
        mul_sel_t mul;
        wb_sel_t  wb;
        logic     advance;
        logic     end_grain;
        logic     out_load;
        logic     out_last;
        logic     out_done;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic done;
        logic copy;
        logic cubic;
        logic start_ok;
        logic stop_now;
    } dp_status_t;

    // Micro-program of one result: each step issues at most one multiply, and
    // most write-backs store a value from the product of the step before.
    function automatic micro_t micro_cmd(mode_t mode, logic [STEP_W-1:0] step);
        micro_t m;
        m = '{mul: MUL_NONE, wb: WB_NONE, fin: 1'b1};
        unique case (mode)
            MODE_CUBIC:
            begin
                unique case (step)
                    5'd0:  m = '{mul: MUL_NONE, wb: WB_TLD,    fin: 1'b0};
                    5'd1:  m = '{mul: MUL_AT,   wb: WB_NONE,   fin: 1'b0};
                    5'd2:  m = '{mul: MUL_CD,   wb: WB_E,      fin: 1'b0};
                    5'd3:  m = '{mul: MUL_ED,   wb: WB_F,      fin: 1'b0};
                    5'd4:  m = '{mul: MUL_TF,   wb: WB_W2N17,  fin: 1'b0};
                    5'd5:  m = '{mul: MUL_EC,   wb: WB_U,      fin: 1'b0};
                    5'd6:  m = '{mul: MUL_UR,   wb: WB_U,      fin: 1'b0};
                    5'd7:  m = '{mul: MUL_UR,   wb: WB_W0N,    fin: 1'b0};
                    5'd8:  m = '{mul: MUL_AF,   wb: WB_W3P,    fin: 1'b0};
                    5'd9:  m = '{mul: MUL_H0,   wb: WB_W1R17,  fin: 1'b0};
                    5'd10: m = '{mul: MUL_H1,   wb: WB_ACCLD,  fin: 1'b0};
                    5'd11: m = '{mul: MUL_H2,   wb: WB_ACCADD, fin: 1'b0};
                    5'd12: m = '{mul: MUL_H3,   wb: WB_ACCADD, fin: 1'b0};
                    5'd13: m = '{mul: MUL_NONE, wb: WB_ACCADD, fin: 1'b0};
                    5'd14: m = '{mul: MUL_NONE, wb: WB_VLD,    fin: 1'b0};
                    5'd15: m = '{mul: MUL_VG,   wb: WB_NONE,   fin: 1'b0};
                    5'd16: m = '{mul: MUL_NONE, wb: WB_OUT,    fin: 1'b1};
                    default: m = '{mul: MUL_NONE, wb: WB_NONE, fin: 1'b1};
                endcase
            end
            MODE_QUAD:
            begin
                unique case (step)
                    5'd0:  m = '{mul: MUL_NONE, wb: WB_TLD,    fin: 1'b0};
                    5'd1:  m = '{mul: MUL_CD,   wb: WB_W0Z,    fin: 1'b0};
                    5'd2:  m = '{mul: MUL_TD,   wb: WB_W1R17,  fin: 1'b0};
                    5'd3:  m = '{mul: MUL_TC,   wb: WB_W2N16,  fin: 1'b0};
                    5'd4:  m = '{mul: MUL_H0,   wb: WB_W3R17,  fin: 1'b0};
                    5'd5:  m = '{mul: MUL_H1,   wb: WB_ACCLD,  fin: 1'b0};
                    5'd6:  m = '{mul: MUL_H2,   wb: WB_ACCADD, fin: 1'b0};
                    5'd7:  m = '{mul: MUL_H3,   wb: WB_ACCADD, fin: 1'b0};
                    5'd8:  m = '{mul: MUL_NONE, wb: WB_ACCADD, fin: 1'b0};
                    5'd9:  m = '{mul: MUL_NONE, wb: WB_VLD,    fin: 1'b0};
                    5'd10: m = '{mul: MUL_VG,   wb: WB_NONE,   fin: 1'b0};
                    5'd11: m = '{mul: MUL_NONE, wb: WB_OUT,    fin: 1'b1};
                    default: m = '{mul: MUL_NONE, wb: WB_NONE, fin: 1'b1};
                endcase
            end
            MODE_COPY:
            begin
                unique case (step)
                    5'd0:  m = '{mul: MUL_NONE, wb: WB_VXLD,   fin: 1'b0};
                    5'd1:  m = '{mul: MUL_VG,   wb: WB_NONE,   fin: 1'b0};
                    5'd2:  m = '{mul: MUL_NONE, wb: WB_OUT,    fin: 1'b1};
                    default: m = '{mul: MUL_NONE, wb: WB_NONE, fin: 1'b1};
                endcase
            end
            default: m = '{mul: MUL_NONE, wb: WB_NONE, fin: 1'b1};
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gtr_dp.sv =====
`default_nettype none

module gtr_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gtr_pkg::in_item_t                 in_data,
    input  logic                              cfg_we,
    input  gtr_pkg::cfg_reg_t                 cfg_index,
    input  logic [gtr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  gtr_pkg::dp_cmd_t                  cmd,
    output gtr_pkg::dp_status_t               status,
    output gtr_pkg::out_item_t                out_data
);
    import gtr_pkg::*;

    localparam logic signed [33:0] T_LO   = -34'(ONE_Q);
    localparam logic signed [33:0] T_HI   = 34'(3 * ONE_Q);
    localparam logic signed [33:0] T_OFS1 = 34'(ONE_Q);
    localparam logic signed [33:0] T_OFS2 = 34'(2 * ONE_Q);
    localparam logic [32:0]        HALF   = 33'(ONE_Q / 2);
    localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Configuration registers.
    logic [INC_W-1:0]   inc_reg;
    logic               cubic_reg;
    logic [TAKEN_W-1:0] frames_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // Grain state.
    logic signed [SAMPLE_BITS-1:0] hist_reg [4];
    logic signed [SAMPLE_BITS-1:0] hist_next [4];
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [TAKEN_W-1:0] taken_reg, taken_next;
    logic               active_reg, active_next;

    // Arithmetic registers.
    logic signed [T_W-1:0]   t_reg;
    logic signed [EF_W-1:0]  e_reg, f_reg;
    logic [U_W-1:0]          u_reg;
    logic signed [W_W-1:0]   w_reg [4];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [V_W-1:0]   v_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg;
    out_item_t               out_reg;

    logic [POS_W-1:0]        base;
    logic [32:0]             pos_sum;
    logic signed [33:0]      t_diff;
    logic signed [T_W-1:0]   t_clamp;
    logic signed [T_W-1:0]   a_val, c_val, d_val;
    logic signed [OP_W-1:0]  op_a, op_b;
    logic signed [P_W-1:0]   rs16, rs17, neg16, neg17, divq, u_sum, q3, wq, wq_neg;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [SAMPLE_BITS-1:0] sat_val;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg    <= INC_W'(UNITY_INC);
            cubic_reg  <= 1'b0;
            frames_reg <= TAKEN_W'(1);
            gain_reg   <= GAIN_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INCREMENT:    inc_reg    <= cfg_data[INC_W-1:0];
                REG_USE_CUBIC:    cubic_reg  <= cfg_data[0];
                REG_GRAIN_FRAMES: frames_reg <= cfg_data[TAKEN_W-1:0];
                REG_GAIN:         gain_reg   <= cfg_data[GAIN_W-1:0];
            endcase
        end
    end

    assign base    = {taken_reg, {FRAC_BITS{1'b0}}};
    assign pos_sum = {1'b0, pos_reg} + 33'(inc_reg);

    // Grain state update on a request, a position step or the grain end.
    always_comb
    begin
        hist_next   = hist_reg;
        pos_next    = pos_reg;
        taken_next  = taken_reg;
        active_next = active_reg;
        if (cmd.accept)
        begin
            if (in_data.first_of_grain)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    hist_next[i] = '0;
                end
                pos_next    = '0;
                taken_next  = '0;
                active_next = 1'b1;
            end
            if (in_data.first_of_grain || active_reg)
            begin
                hist_next[0] = hist_next[1];
                hist_next[1] = hist_next[2];
                hist_next[2] = hist_next[3];
                hist_next[3] = in_data.sample;
                if (taken_next != '1)
                begin
                    taken_next = taken_next + 1'b1;
                end
            end
        end
        if (cmd.advance)
        begin
            pos_next = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
        end
        if (cmd.end_grain)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hist_reg[i] <= '0;
            end
            pos_reg    <= '0;
            taken_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            hist_reg   <= hist_next;
            pos_reg    <= pos_next;
            taken_reg  <= taken_next;
            active_reg <= active_next;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.active = active_reg;
        status.done   = taken_reg >= frames_reg;
        status.copy   = inc_reg == INC_W'(UNITY_INC);
        status.cubic  = cubic_reg;
        if (cubic_reg)
        begin
            status.start_ok = pos_reg < base;
            status.stop_now = pos_reg >= base;
        end
        else
        begin
            status.start_ok = {1'b0, pos_reg} < ({1'b0, base} + HALF);
            status.stop_now = ({1'b0, pos_reg} + HALF) >= {1'b0, base};
        end
    end

    // Fractional offset into the history, clamped to between -1 and +3 frames.
    always_comb
    begin
        t_diff = $signed({2'b00, pos_reg}) - $signed({2'b00, base})
                 + (cubic_reg ? T_OFS1 : T_OFS2);
        if (t_diff < T_LO)
        begin
            t_clamp = T_LO[T_W-1:0];
        end
        else if (t_diff > T_HI)
        begin
            t_clamp = T_HI[T_W-1:0];
        end
        else
        begin
            t_clamp = t_diff[T_W-1:0];
        end
    end

    assign a_val = t_reg + T_W'(ONE_Q);
    assign c_val = t_reg - T_W'(ONE_Q);
    assign d_val = t_reg - T_W'(2 * ONE_Q);

    // Operand selection of the shared multiplier.
    always_comb
    begin
        unique case (cmd.mul)
            MUL_AT:   begin op_a = OP_W'(a_val);      op_b = OP_W'(t_reg); end
            MUL_CD:   begin op_a = OP_W'(c_val);      op_b = OP_W'(d_val); end
            MUL_ED:   begin op_a = OP_W'(e_reg);      op_b = OP_W'(d_val); end
            MUL_TF:   begin op_a = OP_W'(t_reg);      op_b = OP_W'(f_reg); end
            MUL_EC:   begin op_a = OP_W'(e_reg);      op_b = OP_W'(c_val); end
            MUL_UR:   begin op_a = $signed(OP_W'(u_reg)); op_b = OP_W'(RECIP3); end
            MUL_AF:   begin op_a = OP_W'(a_val);      op_b = OP_W'(f_reg); end
            MUL_TD:   begin op_a = OP_W'(t_reg);      op_b = OP_W'(d_val); end
            MUL_TC:   begin op_a = OP_W'(t_reg);      op_b = OP_W'(c_val); end
            MUL_H0:   begin op_a = OP_W'(hist_reg[0]); op_b = OP_W'(w_reg[0]); end
            MUL_H1:   begin op_a = OP_W'(hist_reg[1]); op_b = OP_W'(w_reg[1]); end
            MUL_H2:   begin op_a = OP_W'(hist_reg[2]); op_b = OP_W'(w_reg[2]); end
            MUL_H3:   begin op_a = OP_W'(hist_reg[3]); op_b = OP_W'(w_reg[3]); end
            MUL_VG:   begin op_a = v_reg; op_b = $signed(OP_W'(gain_reg)); end
            default:  begin op_a = '0; op_b = '0; end
        endcase
    end

    // Rounded forms of the registered product.
    always_comb
    begin
        rs16    = (prod_reg + P_W'(ONE_Q / 2)) >>> FRAC_BITS;
        rs17    = (prod_reg + P_W'(ONE_Q)) >>> (FRAC_BITS + 1);
        neg16   = -rs16;
        neg17   = -rs17;
        divq    = (prod_reg + P_W'(RD_BIAS)) >>> (FRAC_BITS + 1);
        u_sum   = divq + P_W'(DIV_OFS);
        q3      = prod_reg >>> RECIP3_SH;
        wq      = q3 - P_W'(DIV_K);
        wq_neg  = -wq;
        acc_rnd = (acc_reg + ACC_W'(ONE_Q / 2)) >>> FRAC_BITS;
        if (rs16 > P_W'(SAT_HI))
        begin
            sat_val = SAT_HI;
        end
        else if (rs16 < P_W'(SAT_LO))
        begin
            sat_val = SAT_LO;
        end
        else
        begin
            sat_val = rs16[SAMPLE_BITS-1:0];
        end
    end

    // Multiplier, product register and write-back.
    always_ff @(posedge clk)
    begin
        prod_reg <= P_W'(op_a) * P_W'(op_b);
        unique case (cmd.wb)
            WB_TLD:    t_reg    <= t_clamp;
            WB_E:      e_reg    <= rs16[EF_W-1:0];
            WB_F:      f_reg    <= rs16[EF_W-1:0];
            WB_U:      u_reg    <= u_sum[U_W-1:0];
            WB_W0Z:    w_reg[0] <= '0;
            WB_W0N:    w_reg[0] <= wq_neg[W_W-1:0];
            WB_W1R17:  w_reg[1] <= rs17[W_W-1:0];
            WB_W2N16:  w_reg[2] <= neg16[W_W-1:0];
            WB_W2N17:  w_reg[2] <= neg17[W_W-1:0];
            WB_W3R17:  w_reg[3] <= rs17[W_W-1:0];
            WB_W3P:    w_reg[3] <= wq[W_W-1:0];
            WB_ACCLD:  acc_reg  <= prod_reg[ACC_W-1:0];
            WB_ACCADD: acc_reg  <= acc_reg + prod_reg[ACC_W-1:0];
            WB_VLD:    v_reg    <= acc_rnd[V_W-1:0];
            WB_VXLD:   v_reg    <= V_W'(hist_reg[3]);
            WB_OUT:    res_reg  <= sat_val;
            default:   ;
        endcase
        if (cmd.out_load)
        begin
            out_reg.out_sample  <= res_reg;
            out_reg.last_of_run <= cmd.out_last;
            out_reg.grain_done  <= cmd.out_done;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gtr_ctrl.sv =====
`default_nettype none

module gtr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output gtr_pkg::dp_cmd_t     cmd,
    input  gtr_pkg::dp_status_t  status
);
    import gtr_pkg::*;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic               single_reg, single_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               fin_run;
    micro_t             micro;

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign micro     = micro_cmd(mode_reg, step_reg);

    // State and sequencing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_QUAD;
            single_reg    <= 1'b0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            single_reg    <= single_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        single_next = single_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        fin_run     = 1'b0;
        cmd         = '{accept: 1'b0, mul: MUL_NONE, wb: WB_NONE, advance: 1'b0,
                        end_grain: 1'b0, out_load: 1'b0, out_last: 1'b0,
                        out_done: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                single_next = status.copy || status.done;
                mode_next   = status.copy ? MODE_COPY
                            : (status.cubic ? MODE_CUBIC : MODE_QUAD);
                step_next   = '0;
                cnt_next    = '0;
                if (status.active &&
                    (status.copy || status.done || status.start_ok))
                begin
                    state_next = S_CALC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CALC:
            begin
                cmd.mul = micro.mul;
                cmd.wb  = micro.wb;
                if (micro.fin)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_ADV:
            begin
                cmd.advance   = 1'b1;
                cmd.end_grain = single_reg && status.done;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                fin_run = single_reg || status.stop_now
                          || (cnt_reg == CNT_W'(MAX_OUT - 1));
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = fin_run;
                    cmd.out_done = single_reg && status.done;
                    step_next    = '0;
                    if (fin_run)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_CALC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output register occupancy.
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/grain_transposing_resampler_top.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_data: sample, first_of_grain
// out      output     out_valid / out_stall  out_data: out_sample, last_of_run, grain_done
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request is taken in and sorted, then each result runs a micro-program
// on one shared 32x32 multiplier; quadratic results, cubic results and
// copied samples each have their own program.
// A request that gives no result returns to idle once sorted; one input is handled at a time.
// Reset is asynchronous and active low; it restores the register defaults.
// A stalled output holds the sequencer in its emit step until taken.
`default_nettype none

module grain_transposing_resampler_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  gtr_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output gtr_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  gtr_pkg::cfg_reg_t               cfg_index,
    input  logic [gtr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gtr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    gtr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    gtr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/gtr_check.sv =====
`default_nettype none
`include "assert_macros.svh"

module gtr_check (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire gtr_pkg::out_item_t              out_data
);
    // A stalled result stays put.
    `GTR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // An accepted request keeps the input busy in the next cycle.
    `GTR_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)

    // The final result of a grain also closes its run.
    `GTR_ASSERT_IMP(a_done_is_last, clk, rst_n, out_valid && out_data.grain_done, out_data.last_of_run)

endmodule

bind grain_transposing_resampler_top gtr_check u_check (.*);

`default_nettype wire

// ===== bench/tb_grain_transposing_resampler_top.sv =====
`default_nettype none

module tb_grain_transposing_resampler_top;
    import gtr_pkg::*;

    localparam longint QONE = 64'sd65536;
    localparam longint POS_TOP = 64'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 1500000;

    // Mirror of the resampler state plus the queue of samples it should produce.
    class grain_sample_board;
        longint hist [4];
        longint unsigned pos;
        int unsigned taken;
        bit need_fetch;
        bit active;
        longint unsigned inc;
        bit cubic;
        int unsigned frames;
        longint gain;
        out_item_t expected_samples [$];
        int errors;

        function new();
            inc = 65536;
            cubic = 0;
            frames = 1;
            gain = 65536;
            foreach (hist[i]) hist[i] = 0;
            pos = 0;
            taken = 0;
            need_fetch = 1;
            active = 0;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, longint unsigned v);
            case (idx)
                REG_INCREMENT: inc = v & 21'h1FFFFF;
                REG_USE_CUBIC: cubic = v[0];
                REG_GRAIN_FRAMES: frames = 32'(v & 64'hFFFF);
                REG_GAIN: gain = v & 17'h1FFFF;
                default: ;
            endcase
        endfunction

        // Rounds half up, then drops s fraction bits with a floor.
        function longint round_q(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        // Division by a positive constant, rounded half up.
        function longint round_by(longint n, longint d);
            n = n + d / 2;
            if (n >= 0)
                return n / d;
            return -((-n + d - 1) / d);
        endfunction

        function longint lagrange_point();
            longint t, a, c, d, e, f, w0, w1, w2, w3, acc;
            t = longint'(pos) - (longint'(taken) <<< 16) + (cubic ? QONE : 2 * QONE);
            if (t < -QONE) t = -QONE;
            if (t > 3 * QONE) t = 3 * QONE;
            if (cubic)
            begin
                a = t + QONE;
                c = t - QONE;
                d = t - 2 * QONE;
                e = round_q(a * t, 16);
                f = round_q(c * d, 16);
                w0 = -round_by(t * f, 6 * QONE);
                w1 = round_q(a * f, 17);
                w2 = -round_q(e * d, 17);
                w3 = round_by(e * c, 6 * QONE);
                acc = hist[0] * w0 + hist[1] * w1 + hist[2] * w2 + hist[3] * w3;
            end
            else
            begin
                w1 = round_q((t - QONE) * (t - 2 * QONE), 17);
                w2 = -round_q(t * (t - 2 * QONE), 16);
                w3 = round_q(t * (t - QONE), 17);
                acc = hist[1] * w1 + hist[2] * w2 + hist[3] * w3;
            end
            return round_q(acc, 16);
        endfunction

        function void push_sample(longint v, bit last, bit done);
            out_item_t o;
            longint r;
            r = round_q(v * gain, 16);
            if (r > 64'sd8388607) r = 64'sd8388607;
            if (r < -64'sd8388608) r = -64'sd8388608;
            o.out_sample = r[23:0];
            o.last_of_run = last;
            o.grain_done = done;
            expected_samples.push_back(o);
        endfunction

        function void step_position();
            longint unsigned p;
            p = pos + inc;
            pos = (p > POS_TOP) ? POS_TOP : p;
        endfunction

        function bit fetch_due();
            longint unsigned base;
            base = longint'(taken) << 16;
            return cubic ? (pos >= base) : (pos + 32768 >= base);
        endfunction

        // Works out every sample that one accepted request produces.
        function void note_request(in_item_t req);
            longint x;
            longint unsigned base;
            bit done;
            int n;
            x = longint'(req.sample);
            n = 0;
            if (req.first_of_grain)
            begin
                foreach (hist[i]) hist[i] = 0;
                pos = 0;
                taken = 0;
                need_fetch = 1;
                active = 1;
            end
            if (!active)
                return;
            hist[0] = hist[1];
            hist[1] = hist[2];
            hist[2] = hist[3];
            hist[3] = x;
            if (taken < 16'hFFFF)
                taken++;
            done = (taken >= frames);
            if (inc == 65536)
            begin
                push_sample(x, 1, done);
                step_position();
                if (done) active = 0;
                return;
            end
            if (done)
            begin
                push_sample(lagrange_point(), 1, 1);
                step_position();
                active = 0;
                return;
            end
            base = longint'(taken) << 16;
            if (cubic ? (pos < base) : (pos < base + 32768))
                need_fetch = 0;
            while (!need_fetch && n < MAX_OUT)
            begin
                push_sample(lagrange_point(), 0, 0);
                n++;
                step_position();
                if (fetch_due())
                    need_fetch = 1;
            end
            need_fetch = 1;
            if (n > 0)
                expected_samples[$].last_of_run = 1;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_samples.size() == 0)
            begin
                $error("unexpected result out_sample=%0d", got.out_sample);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            if (got.out_sample !== want.out_sample)
            begin
                $error("out_sample expected %0d got %0d", want.out_sample, got.out_sample);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run expected %0d got %0d", want.last_of_run, got.last_of_run);
                errors++;
            end
            if (got.grain_done !== want.grain_done)
            begin
                $error("grain_done expected %0d got %0d", want.grain_done, got.grain_done);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    cfg_reg_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    grain_sample_board board;
    bit no_idle;
    int stall_left;
    int cycles;
    int requests_sent;

    grain_transposing_resampler_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function int idle_draw();
        return no_idle ? 0 : int'($urandom_range(0, 19));
    endfunction

    // Result side: check every taken result and hold stall for a drawn number of cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                board.check_result(out_data);
                stall_left = idle_draw();
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left > 0);
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sends one request after a drawn gap; valid stays high when the gap is zero.
    task automatic send_request(logic signed [23:0] s, bit first);
        int gap;
        in_item_t req;
        gap = idle_draw();
        req.sample = s;
        req.first_of_grain = first;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_stall);
        board.note_request(req);
        requests_sent++;
    endtask

    // Waits until every expected sample is back and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.expected_samples.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_one(cfg_reg_t idx, longint unsigned v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, v);
    endtask

    task automatic write_regs(longint unsigned inc, bit cub, int unsigned frm, longint unsigned g);
        write_one(REG_INCREMENT, inc);
        write_one(REG_USE_CUBIC, 64'(cub));
        write_one(REG_GRAIN_FRAMES, 64'(frm));
        write_one(REG_GAIN, g);
        cfg_valid <= 1'b0;
    endtask

    function logic signed [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            default: return $signed(24'($urandom));
        endcase
    endfunction

    // One grain: a start request, then samples, with an occasional stray restart when noisy is set.
    task automatic send_grain(int len, bit noisy);
        send_request(rand_sample(), 1);
        for (int i = 0; i < len; i++)
            send_request(rand_sample(), noisy && ($urandom_range(0, 9) == 0));
    endtask

    initial
    begin
        longint unsigned inc;
        int unsigned frm;
        longint unsigned g;
        int phase;
        board = new();
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        cfg_valid = 0;
        cfg_index = REG_INCREMENT;
        cfg_data = '0;
        stall_left = 0;
        cycles = 0;
        requests_sent = 0;
        no_idle = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Reset settings: samples before a grain are ignored, a one-frame copy grain.
        send_request(24'sh123456, 0);
        send_request(24'sh800000, 0);
        send_request(24'sh7FFFFF, 1);
        send_request(24'sh000001, 0);
        drain();

        // Copy mode with extreme samples, then zero gain.
        write_regs(65536, 0, 5, 65536);
        send_request(24'sh800000, 1);
        send_request(24'sh7FFFFF, 0);
        send_request(24'sh000000, 0);
        send_request(-24'sd1, 0);
        send_request(24'sd1, 0);
        drain();
        write_regs(65536, 1, 0, 0);
        send_request(24'sh7FFFFF, 1);
        send_request(24'sh7FFFFF, 0);
        drain();

        // Slowest quadratic step with many results per request, capped per request.
        write_regs(4096, 0, 3, 65536);
        send_request(24'sh7FFFFF, 1);
        send_request(24'sh800000, 0);
        send_request(24'sh7FFFFF, 0);
        drain();

        // Fastest cubic step; overshoot between extremes saturates.
        write_regs(1048576, 1, 4, 65536);
        send_request(24'sh800000, 1);
        send_request(24'sh7FFFFF, 0);
        send_request(24'sh800000, 0);
        send_request(24'sh7FFFFF, 0);
        drain();
        write_regs(40000, 1, 6, 65536);
        send_grain(6, 0);
        drain();

        // Random phases over many settings.
        phase = 0;
        while (requests_sent < 175)
        begin
            no_idle = (phase % 3 == 0);
            case ($urandom_range(0, 6))
                0: inc = 4096;
                1: inc = 1048576;
                2: inc = 65536;
                3: inc = 65535 + $urandom_range(0, 2);
                default: inc = $urandom_range(4096, 1048576);
            endcase
            case ($urandom_range(0, 9))
                0: frm = 65535;
                1: frm = 0;
                default: frm = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 3))
                0: g = 0;
                1: g = 65536;
                default: g = $urandom_range(0, 65536);
            endcase
            write_regs(inc, 1'($urandom_range(0, 1)), frm, g);
            for (int k = 0; k < 2; k++)
                send_grain(int'((frm > 16) ? 16 : frm + $urandom_range(0, 2)), 1'(phase % 2));
            if (phase % 4 == 1)
            begin
                // Hold off mid-grain until all samples are back, then retune the step.
                send_request(rand_sample(), 1);
                send_request(rand_sample(), 0);
                drain();
                write_one(REG_INCREMENT, 64'($urandom_range(4096, 200000)));
                cfg_valid <= 1'b0;
                send_request(rand_sample(), 0);
                send_request(rand_sample(), 0);
            end
            drain();
            phase++;
        end

        drain();
        if (board.errors == 0 && board.expected_samples.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
